>>> rtl/core/ldrlux_pkg.sv
package ldrlux_pkg;

  typedef enum logic [2:0] {
    CfgPullUpOhms    = 3'd0,
    CfgReferenceOhms = 3'd1,
    CfgReferenceLux  = 3'd2,
    CfgFloorLux      = 3'd3,
    CfgCeilingLux    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic zero;
    logic full;
  } flags_t;

  localparam int unsigned OhmsW   = 20;
  localparam int unsigned RefLuxW = 10;
  localparam int unsigned LuxW    = 16;
  localparam int unsigned RW      = 17;
  localparam int unsigned RatioW  = 23;
  localparam int unsigned FracW   = 16;
  localparam int unsigned Div2NW  = OhmsW + FracW;
  localparam int unsigned SqrtVW  = 40;
  localparam int unsigned SqrtRW  = SqrtVW / 2;
  localparam int unsigned Prod1W  = RatioW + SqrtRW;
  localparam int unsigned Prod2W  = Prod1W + RefLuxW;
  localparam int unsigned LuxRawW = Prod2W - 32;

  localparam logic [RW-1:0]     RMinOhms = 17'd100;
  localparam logic [RW-1:0]     RMaxOhms = 17'd100000;
  localparam logic [RatioW-1:0] RatioMax = 23'h7FFFFF;

endpackage

>>> rtl/core/ldrlux_div_cell.sv
module ldrlux_div_cell import ldrlux_pkg::*; #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 12,
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [NW-1:0] num_d;

  assign trial = {rem_i, num_i[NW-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};
  assign rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign num_d = {num_i[NW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      num_o  <= num_d;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

>>> rtl/core/ldrlux_sqrt_cell.sv
module ldrlux_sqrt_cell import ldrlux_pkg::*; #(
  parameter int unsigned VW = 40,
  parameter int unsigned SW = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [VW/2+1:0]   rem_i,
  input  logic [VW/2-1:0]   root_i,
  input  logic [VW-1:0]     val_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [VW/2+1:0]   rem_o,
  output logic [VW/2-1:0]   root_o,
  output logic [VW-1:0]     val_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned HW = VW / 2;

  logic [HW+3:0] rem2;
  logic [HW+3:0] trial;
  logic [HW+3:0] diff;
  logic          ge;

  assign rem2  = {rem_i, val_i[VW-1:VW-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = rem2 >= trial;
  assign diff  = rem2 - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[HW+1:0] : rem2[HW+1:0];
      root_o <= {root_i[HW-2:0], ge};
      val_o  <= {val_i[VW-3:0], 2'b00};
      side_o <= side_i;
    end
  end

endmodule

>>> rtl/core/ldr_adc_to_lux_core.sv
// Converts one photoresistor divider sample to lux per clock cycle while the input is not
// stalled: a row of one-bit restoring divider cells for the resistance, a second row for the
// Q7.16 reference ratio, a row of one-bit square root cells, two multiplier stages and an
// output register. The pipeline advances as a whole; a skid register behind the output lets
// a request enter while a finished result waits, and the input stalls only while that skid
// register is full. Configuration writes are always ready and must happen while no request
// is in flight.
module ldr_adc_to_lux_core import ldrlux_pkg::*; #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ADC_BITS-1:0] adc_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LuxW-1:0]     lux_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [OhmsW-1:0]    cfg_data_i
);

  localparam int unsigned N1 = ADC_BITS + OhmsW;
  localparam logic [ADC_BITS-1:0] Full = '1;

  logic [OhmsW-1:0]   pull_up_q, ref_ohms_q;
  logic [RefLuxW-1:0] ref_lux_q;
  logic [LuxW-1:0]    floor_q, ceiling_q;

  logic en;
  logic skid_v_q, out_v_q;
  logic [LuxW-1:0] skid_q, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pull_up_q  <= 20'd10000;
      ref_ohms_q <= 20'd10000;
      ref_lux_q  <= 10'd10;
      floor_q    <= 16'd1;
      ceiling_q  <= 16'd2000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPullUpOhms:    pull_up_q  <= cfg_data_i;
        CfgReferenceOhms: ref_ohms_q <= cfg_data_i;
        CfgReferenceLux:  ref_lux_q  <= cfg_data_i[RefLuxW-1:0];
        CfgFloorLux:      floor_q    <= cfg_data_i[LuxW-1:0];
        CfgCeilingLux:    ceiling_q  <= cfg_data_i[LuxW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // Input stage.
  logic                s0_v_q;
  logic [N1-1:0]       s0_num_q;
  logic [ADC_BITS-1:0] s0_den_q;
  flags_t              s0_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_num_q        <= N1'(pull_up_q) * N1'(adc_sample_i);
      s0_den_q        <= Full - adc_sample_i;
      s0_flags_q.zero <= adc_sample_i == '0;
      s0_flags_q.full <= adc_sample_i == Full;
    end
  end

  // Resistance divider row.
  logic                d1_v    [0:N1];
  logic [ADC_BITS-1:0] d1_rem  [0:N1];
  logic [N1-1:0]       d1_num  [0:N1];
  logic [ADC_BITS-1:0] d1_den  [0:N1];
  logic [1:0]          d1_side [0:N1];

  assign d1_v[0]    = s0_v_q;
  assign d1_rem[0]  = '0;
  assign d1_num[0]  = s0_num_q;
  assign d1_den[0]  = s0_den_q;
  assign d1_side[0] = s0_flags_q;

  for (genvar i = 0; i < N1; i++) begin : g_div1
    ldrlux_div_cell #(.NW(N1), .DW(ADC_BITS), .SW(2)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(d1_v[i]), .rem_i(d1_rem[i]), .num_i(d1_num[i]),
      .den_i(d1_den[i]), .side_i(d1_side[i]),
      .valid_o(d1_v[i+1]), .rem_o(d1_rem[i+1]), .num_o(d1_num[i+1]),
      .den_o(d1_den[i+1]), .side_o(d1_side[i+1])
    );
  end

  // Resistance clamp.
  logic          r_v_q;
  logic [RW-1:0] r_q;
  flags_t        r_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (en) begin
      r_v_q <= d1_v[N1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_flags_q <= d1_side[N1];
      if (d1_num[N1] < N1'(RMinOhms)) begin
        r_q <= RMinOhms;
      end else if (d1_num[N1] > N1'(RMaxOhms)) begin
        r_q <= RMaxOhms;
      end else begin
        r_q <= d1_num[N1][RW-1:0];
      end
    end
  end

  // Ratio divider row.
  logic              d2_v    [0:Div2NW];
  logic [RW-1:0]     d2_rem  [0:Div2NW];
  logic [Div2NW-1:0] d2_num  [0:Div2NW];
  logic [RW-1:0]     d2_den  [0:Div2NW];
  logic [1:0]        d2_side [0:Div2NW];

  assign d2_v[0]    = r_v_q;
  assign d2_rem[0]  = '0;
  assign d2_num[0]  = {ref_ohms_q, {FracW{1'b0}}};
  assign d2_den[0]  = r_q;
  assign d2_side[0] = r_flags_q;

  for (genvar i = 0; i < Div2NW; i++) begin : g_div2
    ldrlux_div_cell #(.NW(Div2NW), .DW(RW), .SW(2)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(d2_v[i]), .rem_i(d2_rem[i]), .num_i(d2_num[i]),
      .den_i(d2_den[i]), .side_i(d2_side[i]),
      .valid_o(d2_v[i+1]), .rem_o(d2_rem[i+1]), .num_o(d2_num[i+1]),
      .den_o(d2_den[i+1]), .side_o(d2_side[i+1])
    );
  end

  // Ratio saturation.
  logic              q_v_q;
  logic [RatioW-1:0] q_ratio_q;
  flags_t            q_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
    end else if (en) begin
      q_v_q <= d2_v[Div2NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_flags_q <= d2_side[Div2NW];
      q_ratio_q <= (d2_num[Div2NW] > Div2NW'(RatioMax)) ? RatioMax
                                                         : d2_num[Div2NW][RatioW-1:0];
    end
  end

  // Square root row.
  localparam int unsigned SqSW = RatioW + 2;

  logic              sq_v    [0:SqrtRW];
  logic [SqrtRW+1:0] sq_rem  [0:SqrtRW];
  logic [SqrtRW-1:0] sq_root [0:SqrtRW];
  logic [SqrtVW-1:0] sq_val  [0:SqrtRW];
  logic [SqSW-1:0]   sq_side [0:SqrtRW];

  assign sq_v[0]    = q_v_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_val[0]  = {1'b0, q_ratio_q, {FracW{1'b0}}};
  assign sq_side[0] = {q_flags_q, q_ratio_q};

  for (genvar i = 0; i < SqrtRW; i++) begin : g_sqrt
    ldrlux_sqrt_cell #(.VW(SqrtVW), .SW(SqSW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sq_v[i]), .rem_i(sq_rem[i]), .root_i(sq_root[i]),
      .val_i(sq_val[i]), .side_i(sq_side[i]),
      .valid_o(sq_v[i+1]), .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1]),
      .val_o(sq_val[i+1]), .side_o(sq_side[i+1])
    );
  end

  // Products.
  logic              m1_v_q, m2_v_q;
  logic [Prod1W-1:0] m1_q;
  logic [Prod2W-1:0] m2_q;
  flags_t            m1_flags_q, m2_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= sq_v[SqrtRW];
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_flags_q <= sq_side[SqrtRW][SqSW-1:RatioW];
      m1_q       <= Prod1W'(sq_side[SqrtRW][RatioW-1:0]) * Prod1W'(sq_root[SqrtRW]);
      m2_flags_q <= m1_flags_q;
      m2_q       <= Prod2W'(m1_q) * Prod2W'(ref_lux_q);
    end
  end

  // Clamp and output.
  logic [LuxRawW-1:0] raw;
  logic [LuxRawW-1:0] floored;
  logic [LuxW-1:0]    lux_res;

  assign raw     = m2_q[Prod2W-1:32];
  assign floored = (raw < LuxRawW'(floor_q)) ? LuxRawW'(floor_q) : raw;

  always_comb begin
    if (m2_flags_q.zero) begin
      lux_res = '0;
    end else if (m2_flags_q.full) begin
      lux_res = ceiling_q;
    end else if (floored > LuxRawW'(ceiling_q)) begin
      lux_res = ceiling_q;
    end else begin
      lux_res = floored[LuxW-1:0];
    end
  end

  logic take;
  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= m2_v_q;
      end
    end else if (m2_v_q && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : lux_res;
    end else if (m2_v_q && en) begin
      skid_q <= lux_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign lux_o       = out_q;

  skid_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output is empty");

  blocked_result_parks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i && !skid_v_q && m2_v_q) |=> skid_v_q)
    else $error("finished result was not parked while the output was stalled");

  lux_under_ceiling : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !cfg_valid_i) |-> (out_q <= ceiling_q))
    else $error("lux result exceeds the ceiling");

endmodule

>>> bench/tb_ldr_adc_to_lux_core.sv
`timescale 1ns / 100ps

module tb_ldr_adc_to_lux_core;
  import ldrlux_pkg::*;

  localparam int unsigned AdcBits = 12;
  localparam int unsigned Latency = AdcBits + 82;
  localparam logic [AdcBits-1:0] FullScale = {AdcBits{1'b1}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [AdcBits-1:0]  adc_sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LuxW-1:0]     lux_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = '0;
  logic [OhmsW-1:0]    cfg_data_i = '0;

  ldr_adc_to_lux_core #(.ADC_BITS(AdcBits)) uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [OhmsW-1:0]   pull_up_q = 20'd10000;
  logic [OhmsW-1:0]   ref_ohms_q = 20'd10000;
  logic [RefLuxW-1:0] ref_lux_q = 10'd10;
  logic [LuxW-1:0]    floor_q = 16'd1;
  logic [LuxW-1:0]    ceil_q = 16'd2000;

  logic [AdcBits-1:0] pending_samples[$];
  logic [LuxW-1:0]    expected_lux[$];
  int unsigned        errors = 0;
  int unsigned        accepted = 0;
  int unsigned        checked = 0;
  int unsigned        hold_cycles = 0;
  bit                 driving = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [LuxW-1:0] sample_to_lux(logic [AdcBits-1:0] s);
    logic [63:0] r;
    logic [63:0] ratio;
    logic [63:0] root;
    logic [63:0] lux;
    if (s == 0) return '0;
    if (s == FullScale) return ceil_q;
    r = (64'(pull_up_q) * 64'(s)) / (64'(FullScale) - 64'(s));
    if (r < 100) r = 100;
    if (r > 100000) r = 100000;
    ratio = (64'(ref_ohms_q) << 16) / r;
    if (ratio > 64'h7FFFFF) ratio = 64'h7FFFFF;
    root = int_sqrt(ratio << 16);
    lux = (64'(ref_lux_q) * ratio * root) >> 32;
    if (lux < 64'(floor_q)) lux = 64'(floor_q);
    if (lux > 64'(ceil_q)) lux = 64'(ceil_q);
    return lux[LuxW-1:0];
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver: offers pending requests with random gaps.
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_lux.push_back(sample_to_lux(adc_sample_i));
      accepted++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (driving && pending_samples.size() != 0) begin
        adc_sample_i <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls.
  int unsigned out_gap = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_lux.size() == 0) begin
        $display("%0t: unexpected result lux=%0d", $time, lux_o);
        errors++;
      end else begin
        logic [LuxW-1:0] want;
        want = expected_lux.pop_front();
        checked++;
        if (lux_o !== want) begin
          $display("%0t: lux mismatch expected %0d actual %0d", $time, want, lux_o);
          errors++;
        end
      end
    end
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap <= gap_len();
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [OhmsW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgPullUpOhms:    pull_up_q = value;
      CfgReferenceOhms: ref_ohms_q = value;
      CfgReferenceLux:  ref_lux_q = value[RefLuxW-1:0];
      CfgFloorLux:      floor_q = value[LuxW-1:0];
      CfgCeilingLux:    ceil_q = value[LuxW-1:0];
      default: ;
    endcase
  endtask

  task automatic run_batch(int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: pending_samples.push_back(AdcBits'($urandom_range(0, 3)));
        1: pending_samples.push_back(FullScale - AdcBits'($urandom_range(0, 3)));
        2: pending_samples.push_back(AdcBits'($urandom_range(1, 64)));
        default: pending_samples.push_back(AdcBits'($urandom()));
      endcase
    end
    driving = 1'b1;
    wait (pending_samples.size() == 0 && !in_valid_i);
    wait (expected_lux.size() == 0);
    driving = 1'b0;
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  initial begin
    logic [AdcBits-1:0] directed[$];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    directed = '{12'd0, 12'd1, 12'd2, FullScale, FullScale - 12'd1, FullScale - 12'd2,
                 12'h800, 12'h7FF, 12'h555, 12'hAAA, 12'd100, 12'd3000, 12'h001, 12'h400,
                 12'hF00};
    foreach (directed[i]) pending_samples.push_back(directed[i]);
    driving = 1'b1;
    wait (pending_samples.size() == 0 && !in_valid_i);
    wait (expected_lux.size() == 0);
    driving = 1'b0;
    repeat (Latency + 10) @(posedge clk_i);

    // A long receiver hold-off while requests keep coming fills the pipeline.
    for (int i = 0; i < 150; i++) pending_samples.push_back(AdcBits'($urandom()));
    hold_cycles = 300;
    run_batch(0);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgPullUpOhms, 20'd100);
          write_reg(CfgReferenceOhms, 20'd1000000);
          write_reg(CfgReferenceLux, 20'd1000);
          write_reg(CfgFloorLux, 20'd0);
          write_reg(CfgCeilingLux, 20'd65535);
        end
        1: begin
          write_reg(CfgPullUpOhms, 20'd1000000);
          write_reg(CfgReferenceOhms, 20'd100);
          write_reg(CfgReferenceLux, 20'd1);
          write_reg(CfgFloorLux, 20'd65535);
          write_reg(CfgCeilingLux, 20'd1);
        end
        2: begin
          write_reg(CfgPullUpOhms, 20'd0);
          write_reg(CfgReferenceOhms, 20'd0);
          write_reg(CfgFloorLux, 20'd5);
          write_reg(CfgCeilingLux, 20'd40000);
        end
        3: begin
          write_reg(CfgPullUpOhms, 20'hFFFFF);
          write_reg(CfgReferenceOhms, 20'hFFFFF);
          write_reg(CfgReferenceLux, 20'h3FF);
          write_reg(CfgFloorLux, 20'hFFFF);
          write_reg(CfgCeilingLux, 20'hFFFF);
        end
        default: begin
          write_reg(CfgPullUpOhms, OhmsW'($urandom_range(100, 1000000)));
          write_reg(CfgReferenceOhms, OhmsW'($urandom_range(100, 1000000)));
          write_reg(CfgReferenceLux, OhmsW'($urandom_range(1, 1000)));
          write_reg(CfgFloorLux, OhmsW'($urandom_range(0, 200)));
          write_reg(CfgCeilingLux, OhmsW'($urandom_range(1000, 65535)));
        end
      endcase
      run_batch(100);
    end

    $display("Covered %0d requests and checked %0d results over eight register settings,",
             accepted, checked);
    $display("including register extremes, clamping and a long output hold-off.");
    if (errors == 0) begin
      $display("ldr_adc_to_lux_core regression: pass");
    end else begin
      $display("ldr_adc_to_lux_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ldr_adc_to_lux_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ldrlux_pkg.sv
rtl/core/ldrlux_div_cell.sv
rtl/core/ldrlux_sqrt_cell.sv
rtl/core/ldr_adc_to_lux_core.sv
bench/tb_ldr_adc_to_lux_core.sv
